// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. All checks sample on clk and are
// masked while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)

`endif

`endif

// ===== hdl/psf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package psf_pkg;

    localparam int DEPTH    = 64;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int COUNT_W  = $clog2(DEPTH + 1);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Search token that walks the cell row.
    typedef struct packed {
        logic               active;
        logic               want_ok;
        logic [VALUE_W-1:0] want;
        logic               found;
        logic [IDX_W-1:0]   found_pos;
    } tok_t;

    // Broadcast write into one cell.
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] data;
    } wr_t;

    // Reported positions wrap at the width of the result field.
    function automatic logic [POS_W-1:0] out_pos(input logic [IDX_W-1:0] p);
        return POS_W'(p);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/psf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface psf_in_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  value;
    logic                first_item;
    logic                last_item;

    modport source (output valid, output value, output first_item, output last_item,
                    input ready);
    modport sink   (input valid, input value, input first_item, input last_item,
                    output ready);
endinterface

interface psf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  earlier_position;
    logic [5:0]  later_position;

    modport source (output valid, output status, output earlier_position,
                    output later_position, input ready);
    modport sink   (input valid, input status, input earlier_position,
                    input later_position, output ready);
endinterface

`default_nettype wire

// ===== hdl/pair_sum_finder_unit.sv =====
// Pair sum finder: scans a list of signed 32-bit values and reports the first
// element whose partner (target_sum minus value) appeared earlier in the list.
// items: one list element per transaction, with first_item / last_item marks.
//   first_item empties the table before the element is handled.
// results: at most one transaction per list: pair found with both positions,
//   no pair at the end of the list, or overflow when the list outgrows the
//   DEPTH-entry table. Elements after the list is closed are dropped.
// cfg_we / cfg_data: write target_sum; write only while the block is idle.
// Each stored value sits in one cell of a row of DEPTH cells; a search token
// walks the row one cell per clock, so an element that is searched keeps the
// block busy until its token leaves the end of the row, and through the emit
// state as well when it closes the list; its result (if any) is then registered.
// Dropped elements skip the search; overflow elements go straight to the emit
// state. The next element is taken while a result waits on results; if the
// receiver stalls, a second result holds the block until it drains.
// Reset clears target_sum, the fill count and the list flags; the stored
// values need no clearing since only positions below the fill count are read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pair_sum_finder_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic signed [31:0] cfg_data,
    psf_in_if.sink                  items,
    psf_out_if.source               results
);
    import psf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]          state_reg,  state_next;
    logic [VALUE_W-1:0]  target_reg;
    logic [COUNT_W-1:0]  count_reg,  count_next;
    logic                done_reg,   done_next;
    tok_t                query_reg,  query_next;
    logic [VALUE_W-1:0]  val_reg,    val_next;
    logic [IDX_W-1:0]    pos_reg,    pos_next;
    logic                last_reg,   last_next;
    logic [STATUS_W-1:0] pend_status_reg,  pend_status_next;
    logic [POS_W-1:0]    pend_earlier_reg, pend_earlier_next;
    logic [POS_W-1:0]    pend_later_reg,   pend_later_next;
    logic                out_valid_reg,    out_valid_next;
    logic [STATUS_W-1:0] out_status_reg,   out_status_next;
    logic [POS_W-1:0]    out_earlier_reg,  out_earlier_next;
    logic [POS_W-1:0]    out_later_reg,    out_later_next;

    logic                accept;
    logic                eff_done;
    logic [COUNT_W-1:0]  eff_count;
    logic [VALUE_W:0]    want_wide;
    wr_t                 wr;
    tok_t                tail;
    logic                out_free;

    assign items.ready = (state_reg == ST_IDLE);
    assign accept      = items.valid && items.ready;
    assign out_free    = !out_valid_reg || results.ready;

    assign eff_done  = items.first_item ? 1'b0 : done_reg;
    assign eff_count = items.first_item ? '0 : count_reg;

    // 33-bit complement; it can match only when it fits in 32 bits.
    assign want_wide = {target_reg[VALUE_W-1], target_reg}
                     - {items.value[VALUE_W-1], $unsigned(items.value)};

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        done_next         = done_reg;
        query_next        = query_reg;
        query_next.active = 1'b0;
        val_next          = val_reg;
        pos_next          = pos_reg;
        last_next         = last_reg;
        pend_status_next  = pend_status_reg;
        pend_earlier_next = pend_earlier_reg;
        pend_later_next   = pend_later_reg;
        out_valid_next    = out_valid_reg && !results.ready;
        out_status_next   = out_status_reg;
        out_earlier_next  = out_earlier_reg;
        out_later_next    = out_later_reg;
        wr                = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = eff_count;
                    done_next  = eff_done;
                    if (!eff_done)
                    begin
                        if (eff_count >= COUNT_W'(DEPTH))
                        begin
                            done_next         = 1'b1;
                            pend_status_next  = STATUS_OVERFLOW;
                            pend_earlier_next = '0;
                            pend_later_next   = '0;
                            state_next        = ST_EMIT;
                        end
                        else
                        begin
                            query_next.active    = 1'b1;
                            query_next.want_ok   = (want_wide[VALUE_W] == want_wide[VALUE_W-1]);
                            query_next.want      = want_wide[VALUE_W-1:0];
                            query_next.found     = 1'b0;
                            query_next.found_pos = '0;
                            val_next             = $unsigned(items.value);
                            pos_next             = eff_count[IDX_W-1:0];
                            last_next            = items.last_item;
                            state_next           = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tail.active)
                begin
                    if (tail.found)
                    begin
                        done_next         = 1'b1;
                        pend_status_next  = STATUS_FOUND;
                        pend_earlier_next = out_pos(tail.found_pos);
                        pend_later_next   = out_pos(pos_reg);
                        state_next        = ST_EMIT;
                    end
                    else
                    begin
                        // Append the element behind the live entries.
                        wr.en      = 1'b1;
                        wr.idx     = pos_reg;
                        wr.data    = val_reg;
                        count_next = count_reg + COUNT_W'(1);
                        if (last_reg)
                        begin
                            done_next         = 1'b1;
                            pend_status_next  = STATUS_NONE;
                            pend_earlier_next = '0;
                            pend_later_next   = '0;
                            state_next        = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                // Hold until the output register can take the result.
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = pend_status_reg;
                    out_earlier_next = pend_earlier_reg;
                    out_later_next   = pend_later_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    psf_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .fill  (count_reg),
        .wr    (wr),
        .head  (query_reg),
        .tail  (tail)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            query_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            query_reg     <= query_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                target_reg <= $unsigned(cfg_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg          <= val_next;
        pos_reg          <= pos_next;
        last_reg         <= last_next;
        pend_status_reg  <= pend_status_next;
        pend_earlier_reg <= pend_earlier_next;
        pend_later_reg   <= pend_later_next;
        out_status_reg   <= out_status_next;
        out_earlier_reg  <= out_earlier_next;
        out_later_reg    <= out_later_next;
    end

    assign results.valid            = out_valid_reg;
    assign results.status           = out_status_reg;
    assign results.earlier_position = out_earlier_reg;
    assign results.later_position   = out_later_reg;

    `ASSERT_IMPLIES(a_tail_in_search, tail.active, state_reg == ST_SEARCH, "stray token")
    `ASSERT_IMPLIES(a_query_in_search, query_reg.active, state_reg == ST_SEARCH, "stray query")
    `ASSERT_ALWAYS(a_fill_bound, count_reg <= COUNT_W'(DEPTH), "fill count beyond depth")
    `ASSERT_IMPLIES(a_found_order, tail.found, tail.found_pos < pos_reg, "late partner")

endmodule

`default_nettype wire

// ===== hdl/psf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psf_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [psf_pkg::IDX_W-1:0]   index,
    input  wire logic [psf_pkg::COUNT_W-1:0] fill,
    input  wire psf_pkg::wr_t             wr,
    input  wire psf_pkg::tok_t            tok_in,
    output psf_pkg::tok_t                 tok_out
);
    import psf_pkg::*;

    logic [VALUE_W-1:0] value_reg;
    tok_t               tok_reg;
    tok_t               tok_next;
    logic               occupied;
    logic               hit;

    // Entries below the fill count are the live part of the list.
    assign occupied = COUNT_W'(index) < fill;
    assign hit = tok_in.active && tok_in.want_ok && !tok_in.found && occupied
                 && (value_reg == tok_in.want);

    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.found     = 1'b1;
            tok_next.found_pos = index;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.idx == index))
        begin
            value_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== hdl/psf_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psf_chain (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [psf_pkg::COUNT_W-1:0] fill,
    input  wire psf_pkg::wr_t             wr,
    input  wire psf_pkg::tok_t            head,
    output psf_pkg::tok_t                 tail
);
    import psf_pkg::*;

    tok_t link [0:DEPTH];

    assign link[0] = head;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        psf_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .index   (IDX_W'(g)),
            .fill    (fill),
            .wr      (wr),
            .tok_in  (link[g]),
            .tok_out (link[g+1])
        );
    end

    assign tail = link[DEPTH];

endmodule

`default_nettype wire

// ===== verif/pair_sum_checker.sv =====
`timescale 1ns / 1ps

module pair_sum_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic signed [31:0] cfg_data,
    psf_in_if                  items,
    psf_out_if                 results,
    output int                 mismatches,
    output int                 outstanding,
    output int                 handled_items,
    output int                 reports_checked
);

    import psf_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    earlier;
        logic [POS_W-1:0]    later;
    } pair_report_t;

    logic signed [31:0] target_sum;
    logic signed [31:0] seen_values [DEPTH];
    int                 fill;
    bit                 list_closed;
    pair_report_t       awaited_reports [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void close_with(input logic [STATUS_W-1:0] status,
                                       input int earlier, input int later);
        pair_report_t r;
        r.status  = status;
        r.earlier = POS_W'(earlier);
        r.later   = POS_W'(later);
        awaited_reports.push_back(r);
        list_closed = 1'b1;
    endfunction

    // Work out what one accepted list element leads to.
    function automatic void scan_element(input logic signed [31:0] value,
                                         input logic first_item, input logic last_item);
        logic [32:0] partner;
        if (first_item)
        begin
            fill        = 0;
            list_closed = 1'b0;
        end
        if (list_closed)
            return;
        handled_items++;
        if (fill >= DEPTH)
        begin
            close_with(STATUS_OVERFLOW, 0, 0);
            return;
        end
        // partner is 33 bits wide; a value outside 32 bits matches nothing
        partner = {target_sum[31], target_sum} - {value[31], value};
        for (int k = 0; k < fill; k++)
        begin
            if ({seen_values[k][31], seen_values[k]} == partner)
            begin
                close_with(STATUS_FOUND, k, fill);
                return;
            end
        end
        seen_values[fill] = value;
        fill++;
        if (last_item)
            close_with(STATUS_NONE, 0, 0);
    endfunction

    task automatic check_report();
        pair_report_t want;
        if (awaited_reports.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result status %0d positions %0d/%0d",
                                      results.status, results.earlier_position,
                                      results.later_position));
            return;
        end
        want = awaited_reports.pop_front();
        reports_checked++;
        if (results.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", results.status, want.status));
        if (results.earlier_position !== want.earlier)
            report_mismatch($sformatf("earlier_position %0d, want %0d",
                                      results.earlier_position, want.earlier));
        if (results.later_position !== want.later)
            report_mismatch($sformatf("later_position %0d, want %0d",
                                      results.later_position, want.later));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_sum      = '0;
            fill            = 0;
            list_closed     = 1'b0;
            mismatches      = 0;
            handled_items   = 0;
            reports_checked = 0;
            awaited_reports.delete();
        end
        else
        begin
            // results come from earlier elements, so compare before predicting
            if (results.valid && results.ready)
                check_report();
            if (items.valid && items.ready)
                scan_element(items.value, items.first_item, items.last_item);
            if (cfg_we)
                target_sum = cfg_data;
        end
        outstanding = awaited_reports.size();
    end

endmodule

// ===== verif/pair_sum_finder_unit_tb.sv =====
`timescale 1ns / 1ps

module pair_sum_finder_unit_tb;

    import psf_pkg::*;

    localparam int ITEM_GOAL  = 1550;
    localparam int PHASES     = 8;
    localparam int HOLD_TICKS = DEPTH + 8;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic signed [31:0] cfg_data;
    bit                 steady;
    logic signed [31:0] cur_target;
    logic signed [31:0] list_vals [$];
    int                 lists_sent;

    int mismatches;
    int outstanding;
    int handled_items;
    int reports_checked;

    psf_in_if  items_ch ();
    psf_out_if results_ch ();

    pair_sum_finder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .items    (items_ch),
        .results  (results_ch)
    );

    pair_sum_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .items           (items_ch),
        .results         (results_ch),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .handled_items   (handled_items),
        .reports_checked (reports_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results_ch.ready <= steady || ($urandom_range(0, 99) >= 32);
        end
    end

    initial
    begin
        #20_000_000;
        $display("pair_sum_finder_unit regression: fail");
        $finish;
    end

    task automatic push_item(input logic signed [31:0] value, input logic first_item,
                             input logic last_item);
        int gap;
        if (!steady && $urandom_range(0, 99) < 32)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 90) : $urandom_range(1, 3);
            repeat (gap)
            begin
                @(negedge clk);
                items_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        items_ch.valid      <= 1'b1;
        items_ch.value      <= value;
        items_ch.first_item <= first_item;
        items_ch.last_item  <= last_item;
        list_vals.push_back(value);
        do
            @(posedge clk);
        while (!items_ch.ready);
    endtask

    // Let every awaited result arrive, then give the search row time to empty.
    task automatic drain();
        @(negedge clk);
        items_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (HOLD_TICKS) @(negedge clk);
    endtask

    task automatic set_target(input logic signed [31:0] t);
        drain();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= t;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_target = t;
    endtask

    function automatic logic signed [31:0] pick_value(input bit no_pair);
        logic signed [31:0] v;
        logic signed [31:0] e;
        logic [32:0]        comp;
        bit                 clash;
        int                 r;
        if (no_pair)
        begin
            do
            begin
                v     = $urandom;
                comp  = {cur_target[31], cur_target} - {v[31], v};
                clash = 1'b0;
                foreach (list_vals[i])
                    if ({list_vals[i][31], list_vals[i]} == comp)
                        clash = 1'b1;
            end
            while (clash);
            return v;
        end
        r = $urandom_range(0, 99);
        if (r < 30)
            v = $urandom;
        else if (r < 50)
            v = (cur_target >>> 1) + $signed($urandom_range(0, 8)) - 4;
        else if (r < 70 && list_vals.size() > 0)
        begin
            // plant the partner of an earlier element when it fits in 32 bits
            e    = list_vals[$urandom_range(0, list_vals.size() - 1)];
            comp = {cur_target[31], cur_target} - {e[31], e};
            v    = (comp[32] == comp[31]) ? comp[31:0] : $urandom;
        end
        else if (r < 85)
        begin
            case ($urandom_range(0, 5))
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7fff_ffff;
                2:       v = '0;
                3:       v = -1;
                4:       v = cur_target;
                default: v = 32'sh8000_0001;
            endcase
        end
        else
            v = $signed($urandom_range(0, 15)) - 8;
        return v;
    endfunction

    task automatic send_list(input int len, input bit with_first, input bit with_last,
                             input bit no_pair);
        if (with_first)
            list_vals.delete();
        for (int i = 0; i < len; i++)
            push_item(pick_value(no_pair), with_first && i == 0, with_last && i == len - 1);
        lists_sent++;
    endtask

    task automatic random_list();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 7)
        begin
            // stray elements: dropped when the list is closed, appended otherwise
            repeat ($urandom_range(1, 3))
                push_item(pick_value(1'b0), 1'b0, 1'($urandom_range(0, 1)));
        end
        else if (r < 13)
            send_list($urandom_range(1, 6), 1'b1, 1'b0, 1'b0);
        else if (r < 15)
            send_list(DEPTH + 1 + $urandom_range(0, 2), 1'b1, 1'($urandom_range(0, 1)), 1'b1);
        else if (r < 16)
            send_list(DEPTH, 1'b1, 1'b1, 1'b1);
        else
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            send_list(len, 1'b1, 1'b1, 1'b0);
        end
    endtask

    initial
    begin
        logic signed [31:0] t;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = '0;
        steady              = 1'b0;
        cur_target          = '0;
        lists_sent          = 0;
        items_ch.valid      = 1'b0;
        items_ch.value      = '0;
        items_ch.first_item = 1'b0;
        items_ch.last_item  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // list that starts at reset, no first_item; the trailing element is dropped
        push_item(32'sd5, 1'b0, 1'b0);
        push_item(-32'sd5, 1'b0, 1'b0);
        push_item(-32'sd5, 1'b0, 1'b1);

        // duplicates report the earliest position; hit on the last element
        set_target(32'sd10);
        push_item(32'sd3, 1'b1, 1'b0);
        push_item(32'sd3, 1'b0, 1'b0);
        push_item(32'sd3, 1'b0, 1'b0);
        push_item(32'sd7, 1'b0, 1'b1);
        // an element never pairs with itself
        push_item(32'sd5, 1'b1, 1'b1);

        // complement of the most negative value is out of range
        set_target(32'sd0);
        push_item(32'sh8000_0000, 1'b1, 1'b0);
        push_item(32'sh8000_0000, 1'b0, 1'b1);
        push_item(32'sh7fff_ffff, 1'b1, 1'b0);
        push_item(32'sh8000_0001, 1'b0, 1'b0);
        push_item(32'sd0, 1'b0, 1'b1);

        set_target(32'sh7fff_ffff);
        push_item(32'sh8000_0000, 1'b1, 1'b0);
        push_item(32'sh7fff_ffff, 1'b0, 1'b0);
        push_item(32'sd0, 1'b0, 1'b1);

        set_target(32'sh8000_0000);
        push_item(-32'sd1, 1'b1, 1'b0);
        push_item(32'sh8000_0001, 1'b0, 1'b0);
        push_item(32'sd0, 1'b1, 1'b0);
        push_item(32'sh8000_0000, 1'b0, 1'b1);
        lists_sent += 8;

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       t = 32'sh7fff_ffff;
                1:       t = 32'sh8000_0000;
                3:       t = $signed($urandom_range(0, 40)) - 20;
                5:       t = '0;
                6:       t = -1;
                default: t = $urandom;
            endcase
            set_target(t);
            steady = (p == 4);
            if (p == 1 || p == 4 || p == 6)
                send_list(DEPTH + 1, 1'b1, 1'b1, 1'b1);
            if (p == 2)
                send_list(DEPTH, 1'b1, 1'b1, 1'b1);
            while (handled_items < ITEM_GOAL * (p + 1) / PHASES)
                random_list();
        end
        steady = 1'b0;

        drain();
        $display("covered %0d handled list elements in %0d lists over %0d target settings",
                 handled_items, lists_sent, PHASES + 4);
        $display("checked %0d results, including full-table and overflow lists",
                 reports_checked);
        if (mismatches == 0)
            $display("pair_sum_finder_unit regression: pass");
        else
            $display("pair_sum_finder_unit regression: fail");
        $finish;
    end

endmodule

// ===== pair_sum_finder_unit.f =====
+incdir+hdl
hdl/psf_pkg.sv
hdl/psf_if.sv
hdl/psf_cell.sv
hdl/psf_chain.sv
hdl/pair_sum_finder_unit.sv
verif/pair_sum_checker.sv
verif/pair_sum_finder_unit_tb.sv
